// File: rtl/lsft_pkg.sv
// shared types and constants of the learning switch forwarding table
`default_nettype none

package lsft_pkg;

  localparam int unsigned AddrW    = 48;
  localparam int unsigned PortW    = 3;
  localparam int unsigned StaticN  = 3;
  localparam int unsigned MaskW    = 8;
  localparam int unsigned ApbAddrW = 6;
  localparam int unsigned ApbDataW = 64;
  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 16;

  // register index, taken from paddr[5:3]
  typedef enum logic [2:0] {
    REG_STATIC_ADDR_A = 3'd0,
    REG_STATIC_ADDR_B = 3'd1,
    REG_STATIC_ADDR_C = 3'd2,
    REG_STATIC_PORTS  = 3'd3,
    REG_STATIC_VALID  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [StaticN-1:0][AddrW-1:0] addr;
    logic [StaticN*PortW-1:0]      ports;
    logic [StaticN-1:0]            valid;
  } static_cfg_t;

  typedef struct packed {
    logic load;    // capture header, restart scan
    logic rd;      // read one learned entry
    logic finish;  // write table, present result
  } lsft_cmd_t;

  typedef struct packed {
    logic cnt_zero;  // learned table empty
    logic rd_last;   // current read is the last learned entry
    logic out_free;  // result register can take a new beat
  } lsft_stat_t;

endpackage

`default_nettype wire

// File: rtl/lsft_ctrl.sv
// sequencer: header accept, table scan, result write-back
`default_nettype none

module lsft_ctrl
  import lsft_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire lsft_stat_t stat_i,
  output lsft_cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   rdy_q;
  logic   accept;

  assign accept     = in_valid_i & rdy_q;
  assign in_ready_o = rdy_q;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE:   cmd_o.load   = accept;
      ST_SCAN:   cmd_o.rd     = 1'b1;
      ST_DRAIN:  cmd_o        = '0;
      ST_FINISH: cmd_o.finish = stat_i.out_free;
      default:   cmd_o        = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rdy_q   <= 1'b1;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            rdy_q   <= 1'b0;
            state_q <= stat_i.cnt_zero ? ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (stat_i.rd_last) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (stat_i.out_free) begin
            rdy_q   <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          rdy_q   <= 1'b1;
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/lsft_dpath.sv
// datapath: learned table memories, match tracking, result register
`default_nettype none

module lsft_dpath
  import lsft_pkg::*;
#(
  parameter int PORT_COUNT  = 8,
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lsft_cmd_t         cmd_i,
  output lsft_stat_t             stat_o,
  input  wire static_cfg_t       cfg_i,
  input  wire logic [PortW-1:0]  in_port_i,
  input  wire logic [AddrW-1:0]  src_addr_i,
  input  wire logic [AddrW-1:0]  dst_addr_i,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic [MaskW-1:0]       out_mask_o,
  output logic                   flooded_o,
  output logic                   learn_dropped_o
);

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(TABLE_DEPTH);

  logic [AddrW-1:0] addr_mem [TABLE_DEPTH];
  logic [PortW-1:0] port_mem [TABLE_DEPTH];

  logic [PortW-1:0] port_q;
  logic [AddrW-1:0] src_q, dst_q;
  logic [AddrW-1:0] rd_addr_q;
  logic [PortW-1:0] rd_port_q;

  logic [CntW-1:0]  cnt_q, rd_idx_q;
  logic             rvalid_q;
  logic [IdxW-1:0]  cmp_idx_q;
  logic             src_hit_q, dst_hit_q;
  logic [IdxW-1:0]  src_idx_q, dst_idx_q;
  logic [PortW-1:0] dst_port_q;

  logic             out_valid_q;
  logic [MaskW-1:0] out_mask_q;
  logic             flooded_q, dropped_q;

  logic             st_src_hit, st_dst_hit;
  logic [PortW-1:0] st_dst_port;
  logic             learn, room, upd, app, drop;
  logic             hit;
  logic [PortW-1:0] hit_port;
  logic [MaskW-1:0] all_mask, hit_mask, in_mask, mask;
  logic [IdxW-1:0]  wr_idx;
  logic             we_port, we_addr;

  assign stat_o.cnt_zero = (cnt_q == '0);
  assign stat_o.rd_last  = (rd_idx_q == cnt_q - CntW'(1));
  assign stat_o.out_free = ~out_valid_q | out_ready_i;

  // static entries, first valid match in order a, b, c
  always_comb begin
    st_src_hit  = 1'b0;
    st_dst_hit  = 1'b0;
    st_dst_port = '0;
    for (int k = StaticN - 1; k >= 0; k--) begin
      if (cfg_i.valid[k] && (cfg_i.addr[k] == src_q)) begin
        st_src_hit = 1'b1;
      end
      if (cfg_i.valid[k] && (cfg_i.addr[k] == dst_q)) begin
        st_dst_hit  = 1'b1;
        st_dst_port = cfg_i.ports[k*PortW +: PortW];
      end
    end
  end

  assign learn = ~st_src_hit;
  assign room  = (cnt_q < DepthC);
  assign upd   = learn & src_hit_q;
  assign app   = learn & ~src_hit_q & room;
  assign drop  = learn & ~src_hit_q & ~room;

  // destination resolved as seen after learning the source
  always_comb begin
    hit      = 1'b0;
    hit_port = '0;
    if (st_dst_hit) begin
      hit      = 1'b1;
      hit_port = st_dst_port;
    end else if (dst_hit_q) begin
      hit      = 1'b1;
      hit_port = (upd && (src_idx_q == dst_idx_q)) ? port_q : dst_port_q;
    end else if (app && (dst_q == src_q)) begin
      hit      = 1'b1;
      hit_port = port_q;
    end
  end

  always_comb begin
    for (int b = 0; b < MaskW; b++) begin
      all_mask[b] = (b < PORT_COUNT);
    end
    hit_mask = (int'(hit_port) < PORT_COUNT) ? (MaskW'(1) << hit_port) : '0;
    in_mask  = (int'(port_q) < PORT_COUNT) ? (MaskW'(1) << port_q) : '0;
    mask     = hit ? hit_mask : (all_mask & ~in_mask);
  end

  assign wr_idx  = upd ? src_idx_q : cnt_q[IdxW-1:0];
  assign we_port = cmd_i.finish & (upd | app);
  assign we_addr = cmd_i.finish & app;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_addr_q <= addr_mem[rd_idx_q[IdxW-1:0]];
    end
    if (we_addr) begin
      addr_mem[wr_idx] <= src_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_port_q <= port_mem[rd_idx_q[IdxW-1:0]];
    end
    if (we_port) begin
      port_mem[wr_idx] <= port_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      port_q <= in_port_i;
      src_q  <= src_addr_i;
      dst_q  <= dst_addr_i;
    end
    if (cmd_i.rd) begin
      cmp_idx_q <= rd_idx_q[IdxW-1:0];
    end
    if (cmd_i.finish) begin
      out_mask_q <= mask;
      flooded_q  <= ~hit;
      dropped_q  <= drop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      rvalid_q    <= 1'b0;
      src_hit_q   <= 1'b0;
      src_idx_q   <= '0;
      dst_hit_q   <= 1'b0;
      dst_idx_q   <= '0;
      dst_port_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rvalid_q <= cmd_i.rd;
      if (cmd_i.load) begin
        rd_idx_q  <= '0;
        src_hit_q <= 1'b0;
        dst_hit_q <= 1'b0;
      end else if (cmd_i.rd) begin
        rd_idx_q <= rd_idx_q + CntW'(1);
      end
      // keep only the first match for each address
      if (rvalid_q) begin
        if (!src_hit_q && (rd_addr_q == src_q)) begin
          src_hit_q <= 1'b1;
          src_idx_q <= cmp_idx_q;
        end
        if (!dst_hit_q && (rd_addr_q == dst_q)) begin
          dst_hit_q  <= 1'b1;
          dst_idx_q  <= cmp_idx_q;
          dst_port_q <= rd_port_q;
        end
      end
      if (cmd_i.finish && app) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_mask_o      = out_mask_q;
  assign flooded_o       = flooded_q;
  assign learn_dropped_o = dropped_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthC)
    else $error("learned count beyond table depth");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> (cnt_q == CntW'($past(cnt_q) + CntW'(1))))
    else $error("learned count moved by more than one");

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before taken");

  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!rvalid_q && !cmd_i.rd))
    else $error("header loaded during a scan");

endmodule

`default_nettype wire

// File: rtl/learning_switch_forward_table_core.sv
// top level of the learning switch forwarding table: apb registers, sequencer, datapath
//
// channel    dir  handshake                 payload
// s_axis     in   s_axis_tvalid/tready      tdata: in_port, src_addr, dst_addr
// m_axis     out  m_axis_tvalid/tready      tdata: out_mask, flooded, learn_dropped
// apb        in   psel/penable/pwrite       static_addr_a/b/c, static_ports, static_valid
//
// from accept to result a header runs through the scan of the learned table,
// one entry per memory read, then drain and write-back; an empty table skips the scan
// reset clears the learned count, the config registers and the handshake state; the
// table memory itself is not cleared, only entries below the count are ever read
// a result waits in the output register while the next header is taken and scanned;
// a stalled m_axis only holds the block at write-back

`default_nettype none

module learning_switch_forward_table_core
  import lsft_pkg::*;
#(
  parameter int PORT_COUNT  = 8,
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // header beat
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [2:0] in_port, [50:3] src_addr, [98:51] dst_addr, rest zero
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // result beat
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [7:0] out_mask, [8] flooded, [9] learn_dropped, rest zero
  output logic [OutDataW-1:0]      m_axis_tdata,
  // register port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0]      prdata,
  output logic                     pready
);

  static_cfg_t      cfg_q;
  reg_idx_e         reg_idx;
  logic             cfg_wr;
  lsft_cmd_t        cmd;
  lsft_stat_t       stat;
  logic [MaskW-1:0] out_mask;
  logic             flooded, learn_dropped;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[5:3]);
  assign cfg_wr  = psel & penable & pwrite;

  // static entry registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_STATIC_ADDR_A: cfg_q.addr[0] <= pwdata[AddrW-1:0];
        REG_STATIC_ADDR_B: cfg_q.addr[1] <= pwdata[AddrW-1:0];
        REG_STATIC_ADDR_C: cfg_q.addr[2] <= pwdata[AddrW-1:0];
        REG_STATIC_PORTS:  cfg_q.ports   <= pwdata[StaticN*PortW-1:0];
        REG_STATIC_VALID:  cfg_q.valid   <= pwdata[StaticN-1:0];
        default: ;  // addresses past the register list are ignored
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_STATIC_ADDR_A: prdata = ApbDataW'(cfg_q.addr[0]);
      REG_STATIC_ADDR_B: prdata = ApbDataW'(cfg_q.addr[1]);
      REG_STATIC_ADDR_C: prdata = ApbDataW'(cfg_q.addr[2]);
      REG_STATIC_PORTS:  prdata = ApbDataW'(cfg_q.ports);
      REG_STATIC_VALID:  prdata = ApbDataW'(cfg_q.valid);
      default:           prdata = '0;
    endcase
  end

  lsft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lsft_dpath #(
    .PORT_COUNT  (PORT_COUNT),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_i           (cfg_q),
    .in_port_i       (s_axis_tdata[2:0]),
    .src_addr_i      (s_axis_tdata[50:3]),
    .dst_addr_i      (s_axis_tdata[98:51]),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .out_mask_o      (out_mask),
    .flooded_o       (flooded),
    .learn_dropped_o (learn_dropped)
  );

  assign m_axis_tdata = {6'd0, learn_dropped, flooded, out_mask};

endmodule

`default_nettype wire

// File: verif/tb_learning_switch_forward_table_core.sv
// testbench of the learning switch forwarding table: header stream in, port mask stream out
`default_nettype none

module tb_learning_switch_forward_table_core;
  import lsft_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PortCount  = 8;
  localparam int TableDepth = 64;
  localparam int SegmentCnt = 8;
  localparam int SegmentLen = 172;
  localparam int HoldLen    = 400;
  localparam int DrainLimit = 2000;
  localparam int TailCycles = 100;
  localparam logic [ApbAddrW-1:0] UnmappedAddr = ApbAddrW'(8 * 5);

  // one forwarding decision, same field order as m_axis_tdata from bit 0 up
  typedef struct packed {
    logic             learn_dropped;
    logic             flooded;
    logic [MaskW-1:0] out_mask;
  } fwd_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // [2:0] in_port, [50:3] src_addr, [98:51] dst_addr, rest zero
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // [7:0] out_mask, [8] flooded, [9] learn_dropped, rest zero
  logic [OutDataW-1:0] m_axis_tdata;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // shadow copy of the forwarding state
  logic [AddrW-1:0]         sw_static_addr [StaticN];
  logic [StaticN*PortW-1:0] sw_static_ports;
  logic [StaticN-1:0]       sw_static_valid;
  logic [AddrW-1:0]         sw_learned_addr [TableDepth];
  logic [PortW-1:0]         sw_learned_port [TableDepth];
  int                       sw_learned_cnt;

  // decisions predicted at header accept, retired in order at result accept
  fwd_result_t fwd_expect_q[$];

  int  mismatches;
  int  headers_sent;
  int  results_checked;
  int  floods_seen;
  int  drops_seen;
  int  input_stall_cycles;
  int  rx_hold_cycles;
  bit  tx_gaps_on;
  bit  rx_gaps_on;

  learning_switch_forward_table_core #(
    .PORT_COUNT (PortCount),
    .TABLE_DEPTH(TableDepth)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // forwarding predictor
  // ---------------------------------------------------------------------------

  // static entries are searched a, b, c; first enabled match wins
  function automatic bit static_lookup(input logic [AddrW-1:0] addr,
                                       output logic [PortW-1:0] port);
    port = '0;
    for (int k = 0; k < StaticN; k++) begin
      if (sw_static_valid[k] && sw_static_addr[k] == addr) begin
        port = sw_static_ports[PortW*k +: PortW];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // index of the first learned entry holding addr, -1 if none
  function automatic int learned_index(input logic [AddrW-1:0] addr);
    for (int i = 0; i < sw_learned_cnt; i++) begin
      if (sw_learned_addr[i] == addr) return i;
    end
    return -1;
  endfunction

  // learn the source first, then resolve the destination against the updated table
  function automatic fwd_result_t lookup_and_learn(input logic [PortW-1:0] in_port,
                                                   input logic [AddrW-1:0] src,
                                                   input logic [AddrW-1:0] dst);
    fwd_result_t      r;
    logic [PortW-1:0] hit_port;
    bit               hit;
    int               idx;
    r = '0;
    if (!static_lookup(src, hit_port)) begin
      idx = learned_index(src);
      if (idx >= 0) begin
        sw_learned_port[idx] = in_port;
      end else if (sw_learned_cnt < TableDepth) begin
        sw_learned_addr[sw_learned_cnt] = src;
        sw_learned_port[sw_learned_cnt] = in_port;
        sw_learned_cnt++;
      end else begin
        r.learn_dropped = 1'b1;
      end
    end
    hit = static_lookup(dst, hit_port);
    if (!hit) begin
      idx = learned_index(dst);
      if (idx >= 0) begin
        hit      = 1'b1;
        hit_port = sw_learned_port[idx];
      end
    end
    if (hit) begin
      // a port beyond the populated ones drops the frame
      r.out_mask = (int'(hit_port) < PortCount) ? MaskW'(1) << hit_port : '0;
    end else begin
      r.out_mask = MaskW'((1 << PortCount) - 1);
      if (int'(in_port) < PortCount) r.out_mask[in_port] = 1'b0;
      r.flooded = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [ApbDataW-1:0] shadow_reg(input reg_idx_e idx);
    case (idx)
      REG_STATIC_ADDR_A: return ApbDataW'(sw_static_addr[0]);
      REG_STATIC_ADDR_B: return ApbDataW'(sw_static_addr[1]);
      REG_STATIC_ADDR_C: return ApbDataW'(sw_static_addr[2]);
      REG_STATIC_PORTS:  return ApbDataW'(sw_static_ports);
      REG_STATIC_VALID:  return ApbDataW'(sw_static_valid);
      default:           return '0;
    endcase
  endfunction

  function automatic logic [AddrW-1:0] rand_addr();
    return AddrW'({$urandom, $urandom});
  endfunction

  // random garbage above a register's width, which the block has to drop
  function automatic logic [ApbDataW-1:0] junk_above(input logic [ApbDataW-1:0] v,
                                                     input int w);
    logic [ApbDataW-1:0] keep;
    keep = (ApbDataW'(1) << w) - 1;
    return (v & keep) | ({$urandom, $urandom} & ~keep);
  endfunction

  task automatic log_mismatch(input string what, input logic [ApbDataW-1:0] exp_v,
                              input logic [ApbDataW-1:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch in %s: expected %0h, got %0h", $realtime, what, exp_v, act_v);
  endtask

  // ---------------------------------------------------------------------------
  // register port
  // ---------------------------------------------------------------------------

  task automatic apb_access(input bit wr, input logic [ApbAddrW-1:0] addr,
                            input logic [ApbDataW-1:0] wdata,
                            output logic [ApbDataW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // write one register, mirror it, and read it back
  task automatic write_reg(input reg_idx_e idx, input logic [ApbDataW-1:0] value);
    logic [ApbDataW-1:0] rd;
    apb_access(1'b1, ApbAddrW'({idx, 3'b000}), value, rd);
    case (idx)
      REG_STATIC_ADDR_A: sw_static_addr[0] = value[AddrW-1:0];
      REG_STATIC_ADDR_B: sw_static_addr[1] = value[AddrW-1:0];
      REG_STATIC_ADDR_C: sw_static_addr[2] = value[AddrW-1:0];
      REG_STATIC_PORTS:  sw_static_ports = value[StaticN*PortW-1:0];
      REG_STATIC_VALID:  sw_static_valid = value[StaticN-1:0];
      default: ;
    endcase
    apb_access(1'b0, ApbAddrW'({idx, 3'b000}), '0, rd);
    if (rd !== shadow_reg(idx)) log_mismatch("register readback", shadow_reg(idx), rd);
  endtask

  task automatic write_statics(input logic [AddrW-1:0] a, input logic [AddrW-1:0] b,
                               input logic [AddrW-1:0] c,
                               input logic [StaticN*PortW-1:0] ports,
                               input logic [StaticN-1:0] valid);
    logic [ApbDataW-1:0] rd;
    write_reg(REG_STATIC_ADDR_A, junk_above(ApbDataW'(a), AddrW));
    write_reg(REG_STATIC_ADDR_B, junk_above(ApbDataW'(b), AddrW));
    write_reg(REG_STATIC_ADDR_C, junk_above(ApbDataW'(c), AddrW));
    write_reg(REG_STATIC_PORTS, junk_above(ApbDataW'(ports), StaticN * PortW));
    write_reg(REG_STATIC_VALID, junk_above(ApbDataW'(valid), StaticN));
    // a write past the register map must leave everything alone
    if ($urandom_range(0, 1)) apb_access(1'b1, UnmappedAddr, {$urandom, $urandom}, rd);
  endtask

  // ---------------------------------------------------------------------------
  // header stream
  // ---------------------------------------------------------------------------

  // offer one header, predict its decision once the beat is taken
  task automatic send_header(input logic [PortW-1:0] in_port, input logic [AddrW-1:0] src,
                             input logic [AddrW-1:0] dst);
    int          gap;
    fwd_result_t res;
    gap = tx_gaps_on ? $urandom_range(0, 19) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'({dst, src, in_port});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    res = lookup_and_learn(in_port, src, dst);
    fwd_expect_q.insert(fwd_expect_q.size(), res);
    headers_sent++;
    if (res.flooded) floods_seen++;
    if (res.learn_dropped) drops_seen++;
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // every header gives exactly one result, so an empty queue means the block is idle
  task automatic drain_results();
    for (int w = 0; w < DrainLimit && fwd_expect_q.size() != 0; w++) @(posedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // result stream: receiver stalls, one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      if (rx_hold_cycles > 0) begin
        stall          = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = rx_gaps_on ? $urandom_range(0, 19) : 0;
      end
      if (stall > 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // in-order compare of each result beat with the oldest prediction
  always @(posedge clk_i) begin : result_check
    fwd_result_t want;
    if (rst_ni && s_axis_tvalid && !s_axis_tready) input_stall_cycles++;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (fwd_expect_q.size() == 0) begin
        log_mismatch("unexpected result beat", '0, ApbDataW'(m_axis_tdata));
      end else begin
        want = fwd_expect_q.pop_front();
        results_checked++;
        if (m_axis_tdata[7:0] !== want.out_mask)
          log_mismatch("out_mask", ApbDataW'(want.out_mask), ApbDataW'(m_axis_tdata[7:0]));
        if (m_axis_tdata[8] !== want.flooded)
          log_mismatch("flooded", ApbDataW'(want.flooded), ApbDataW'(m_axis_tdata[8]));
        if (m_axis_tdata[9] !== want.learn_dropped)
          log_mismatch("learn_dropped", ApbDataW'(want.learn_dropped),
                       ApbDataW'(m_axis_tdata[9]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // statics off: learning, relearning, floods and hits on the learned table only
  task automatic test_learning_basics();
    logic [AddrW-1:0] first_src;
    logic [AddrW-1:0] ones;
    first_src = 48'h0200_0000_0001;
    ones      = '1;
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    send_header(3'd2, first_src, ones);               // miss, flood all but port 2
    send_header(3'd5, '0, first_src);                 // zero address learned, hit port 2
    send_header(3'd7, first_src, '0);                 // relearn to port 7, hit port 5
    send_header(3'd0, 48'h1234_5678_9abc, first_src); // follows the move to port 7
    send_header(3'd3, 48'h0a0b_0c0d_0e0f, 48'h0a0b_0c0d_0e0f); // own source, own port
    send_header(3'd7, ones, 48'h5555_aaaa_5555);      // flood from the top port
    send_header(3'd0, 48'h5555_aaaa_5555, ones);      // hit port 7
    send_header(3'd0, 48'haaaa_5555_aaaa, rand_addr()); // flood from port 0
    end_burst();
    drain_results();
  endtask

  // static entries: precedence over learned ones, never relearned, order a-b-c
  task automatic test_static_entries();
    logic [AddrW-1:0] first_src;
    logic [AddrW-1:0] stat_c;
    logic [AddrW-1:0] stat_d;
    first_src = 48'h0200_0000_0001;
    stat_c    = 48'h8000_0000_0000;
    stat_d    = 48'h0000_0000_7777;
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    // a shadows a learned entry, b is all ones, c is the top address bit
    write_statics(first_src, '1, stat_c, {3'd0, 3'd6, 3'd3}, 3'b111);
    send_header(3'd4, stat_c, stat_c);        // static source not learned, hit port 0
    send_header(3'd1, first_src, first_src);  // learned entry untouched, static a wins
    send_header(3'd5, 48'h0000_ffff_0000, '1); // static b, port 6
    end_burst();
    drain_results();
    // only c left: the learned entry behind a still points at port 7
    write_statics(first_src, '1, stat_c, {3'd0, 3'd6, 3'd3}, 3'b100);
    send_header(3'd6, 48'h0000_ffff_0000, first_src);
    send_header(3'd2, '1, '1);                // all-ones is learned again, now port 2
    send_header(3'd3, stat_c, '1);
    end_burst();
    drain_results();
    // same address in a and c: a wins while enabled, then c; zero address static in b
    write_statics(stat_d, '0, stat_d, {3'd5, 3'd4, 3'd1}, 3'b111);
    send_header(3'd0, 48'h1111_2222_3333, stat_d);
    send_header(3'd7, 48'h1111_2222_3333, '0);
    end_burst();
    drain_results();
    write_statics(stat_d, '0, stat_d, {3'd5, 3'd4, 3'd1}, 3'b100);
    send_header(3'd6, stat_d, stat_d);        // port 5 via c
    send_header(3'd1, 48'h4444_0000_4444, '0); // static b off, learned zero on port 5
    end_burst();
    drain_results();
  endtask

  // segments of random traffic over a growing address pool, reprogrammed in between
  task automatic test_random_traffic();
    logic [AddrW-1:0]         addr_pool[$];
    logic [AddrW-1:0]         stat_addr [StaticN];
    logic [StaticN*PortW-1:0] ports;
    logic [StaticN-1:0]       valid;
    logic [AddrW-1:0]         src;
    logic [AddrW-1:0]         dst;
    int                       pick;
    addr_pool.insert(addr_pool.size(), '0);
    addr_pool.insert(addr_pool.size(), '1);
    for (int seg = 0; seg < SegmentCnt; seg++) begin
      // pool grows so the table fills over the first few segments
      while (addr_pool.size() < 24 + 12 * seg) addr_pool.insert(addr_pool.size(), rand_addr());
      for (int k = 0; k < StaticN; k++) begin
        case ($urandom_range(0, 4))
          0:       stat_addr[k] = '0;
          1:       stat_addr[k] = '1;
          2:       stat_addr[k] = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
          default: stat_addr[k] = rand_addr();
        endcase
      end
      ports = (seg == 0) ? '0 : (seg == 1) ? '1 : (StaticN * PortW)'($urandom);
      valid = (seg == 0) ? '0 : (seg == 1) ? '1 : StaticN'($urandom);
      write_statics(stat_addr[0], stat_addr[1], stat_addr[2], ports, valid);
      tx_gaps_on = (seg % 3) != 1;
      rx_gaps_on = (seg % 4) != 2;
      // back-pressure: the sink sits still while headers keep coming back to back
      if (seg == 5) begin
        tx_gaps_on     = 1'b0;
        rx_hold_cycles = HoldLen;
      end
      for (int n = 0; n < SegmentLen; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 88)      src = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
        else if (pick < 97) src = stat_addr[$urandom_range(0, StaticN - 1)];
        else                src = rand_addr();
        pick = $urandom_range(0, 99);
        if (pick < 60)      dst = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
        else if (pick < 75) dst = stat_addr[$urandom_range(0, StaticN - 1)];
        else if (pick < 82) dst = src;
        else                dst = rand_addr();
        send_header(PortW'($urandom), src, dst);
      end
      end_burst();
      drain_results();
    end
  endtask

  // full learned table: new sources are dropped, known ones still move
  task automatic test_full_table();
    logic [AddrW-1:0] stat_a;
    logic [AddrW-1:0] fresh;
    stat_a = 48'h0c0f_fee0_0001;
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    write_statics(stat_a, rand_addr(), rand_addr(), {3'd7, 3'd7, 3'd2}, 3'b001);
    while (sw_learned_cnt < TableDepth) send_header(PortW'($urandom), rand_addr(), '1);
    fresh = rand_addr();
    send_header(3'd4, fresh, sw_learned_addr[0]);                       // dropped
    send_header(3'd1, sw_learned_addr[TableDepth - 1], fresh);         // not stored: flood
    send_header(3'd6, stat_a, sw_learned_addr[TableDepth - 1]);        // hit port 1
    send_header(3'd0, rand_addr(), stat_a);                             // dropped, static hit
    end_burst();
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin : main_seq
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    tx_gaps_on    = 1'b0;
    rx_gaps_on    = 1'b0;
    rx_hold_cycles = 0;
    mismatches    = 0;
    headers_sent  = 0;
    results_checked = 0;
    floods_seen   = 0;
    drops_seen    = 0;
    input_stall_cycles = 0;
    for (int k = 0; k < StaticN; k++) sw_static_addr[k] = '0;
    sw_static_ports = '0;
    sw_static_valid = '0;
    sw_learned_cnt  = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_learning_basics();
    test_static_entries();
    test_random_traffic();
    test_full_table();

    repeat (TailCycles) @(posedge clk_i);
    while (fwd_expect_q.size() != 0) begin
      void'(fwd_expect_q.pop_front());
      log_mismatch("missing result beat", '0, '0);
    end

    $display("ran %0d headers, checked %0d results: %0d floods, %0d learn drops",
             headers_sent, results_checked, floods_seen, drops_seen);
    $display("learned table reached %0d entries, header input stalled %0d cycles",
             sw_learned_cnt, input_stall_cycles);
    if (mismatches == 0) begin
      $display("PASS learning_switch_forward_table_core");
    end else begin
      $display("FAIL learning_switch_forward_table_core");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin : watchdog
    #12_000_000;
    $display("FAIL learning_switch_forward_table_core");
    $finish;
  end

endmodule

`default_nettype wire
